// File: rtl/core/pcs_pkg.sv
// pcs_pkg: shared widths, register indexes, reset values and item structs
// for the contact steepener pipeline.
// No dependencies; every rtl/core module imports it.
package pcs_pkg;

    // Fixed field widths
    localparam int DATA_W = 32;     // signed Q16.16 data words
    localparam int CFG_W  = 31;     // unsigned configuration registers
    localparam int MAG_W  = 32;     // magnitude of a 33-bit difference
    localparam int TGT_W  = 34;     // 2*value +/- slope
    localparam int IDX_W  = 2;      // configuration register index

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_ETA_GAIN   = 2'd0;
    localparam logic [IDX_W-1:0] REG_ETA_OFFSET = 2'd1;
    localparam logic [IDX_W-1:0] REG_JUMP_FRAC  = 2'd2;

    // Reset values (20.0, 0.05, 0.01 in Q16.16)
    localparam logic [CFG_W-1:0] ETA_GAIN_RST   = 31'd1310720;
    localparam logic [CFG_W-1:0] ETA_OFFSET_RST = 31'd3277;
    localparam logic [CFG_W-1:0] JUMP_FRAC_RST  = 31'd655;

    // Data that rides along with an item up to the blend stages
    typedef struct packed {
        logic signed [DATA_W-1:0] edge_lo;
        logic signed [DATA_W-1:0] edge_hi;
        logic signed [TGT_W-1:0]  tgt_lo;   // 2*value_left + slope_left
        logic signed [TGT_W-1:0]  tgt_hi;   // 2*value_right - slope_right
    } t_side;

    // Detection results that travel through the divider
    typedef struct packed {
        logic pass;   // opposite curvature and large enough jump
        logic neg;    // curvature ratio is negative
        logic ovf;    // quotient too large for the divider
    } t_flags;

endpackage

// File: rtl/core/ppa_contact_steepener_unit.sv
// ppa_contact_steepener_unit: top level of the contact steepener pipeline.
// Holds the configuration registers; instantiates pcs_front, pcs_div,
// pcs_eta and pcs_blend. Depends on pcs_pkg.
//
// Usage:
//  - Input channel: i_in_valid / o_in_ready with the eight interface fields.
//    Output channel: o_out_valid / i_out_ready with both blended interface
//    values and the steepened flag.
//  - Configuration: i_cfg_we writes i_cfg_data into register i_cfg_index
//    (0 eta_gain, 1 eta_offset, 2 jump_fraction) at the clock edge; other
//    indexes are ignored. Write only while no item is in flight.
//  - Throughput: one item per cycle, sustained while the output is not stalled.
//  - Pipeline: three front stages, one restoring divider stage per quotient
//    bit (2*FRAC_BITS + 2), four weight stages, and four blend stages ending
//    in the output register.
//  - Stall: the whole pipeline holds while the output register is full and
//    i_out_ready is low; o_in_ready follows that same enable, so nothing is
//    lost or repeated. Bubbles advance whenever the output is free.
//  - Reset (synchronous, active low) empties the pipeline and loads the
//    register defaults 20.0, 0.05 and 0.01.
module ppa_contact_steepener_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [pcs_pkg::IDX_W-1:0]          i_cfg_index,
    input  logic [pcs_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic signed [pcs_pkg::DATA_W-1:0]  i_value_left,
    input  logic signed [pcs_pkg::DATA_W-1:0]  i_value_right,
    input  logic signed [pcs_pkg::DATA_W-1:0]  i_curv_left,
    input  logic signed [pcs_pkg::DATA_W-1:0]  i_curv_right,
    input  logic signed [pcs_pkg::DATA_W-1:0]  i_slope_left,
    input  logic signed [pcs_pkg::DATA_W-1:0]  i_slope_right,
    input  logic signed [pcs_pkg::DATA_W-1:0]  i_edge_low_in,
    input  logic signed [pcs_pkg::DATA_W-1:0]  i_edge_high_in,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [pcs_pkg::DATA_W-1:0]  o_edge_low_out,
    output logic signed [pcs_pkg::DATA_W-1:0]  o_edge_high_out,
    output logic                               o_steepened
);
    import pcs_pkg::*;

    localparam int QUO_W = 2*FRAC_BITS + 2;

    logic [CFG_W-1:0] r_eta_gain;
    logic [CFG_W-1:0] r_eta_offset;
    logic [CFG_W-1:0] r_jump_frac;

    logic             w_en;

    logic             w_fr_valid;
    t_flags           w_fr_flags;
    t_side            w_fr_side;
    logic [MAG_W-1:0] w_fr_rem;
    logic [MAG_W-1:0] w_fr_divisor;
    logic [QUO_W-1:0] w_fr_bits;

    logic             w_dv_valid;
    t_flags           w_dv_flags;
    t_side            w_dv_side;
    logic [QUO_W-1:0] w_dv_quo;

    logic             w_et_valid;
    logic             w_et_steep;
    logic [FRAC_BITS:0] w_et_eta;
    t_side            w_et_side;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eta_gain   <= ETA_GAIN_RST;
            r_eta_offset <= ETA_OFFSET_RST;
            r_jump_frac  <= JUMP_FRAC_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_ETA_GAIN:   r_eta_gain   <= i_cfg_data;
                REG_ETA_OFFSET: r_eta_offset <= i_cfg_data;
                REG_JUMP_FRAC:  r_jump_frac  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Pipeline advances unless a finished item waits at a stalled output
    assign w_en       = !o_out_valid || i_out_ready;
    assign o_in_ready = w_en;

    pcs_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (w_en),
        .i_valid         (i_in_valid),
        .i_value_left    (i_value_left),
        .i_value_right   (i_value_right),
        .i_curv_left     (i_curv_left),
        .i_curv_right    (i_curv_right),
        .i_slope_left    (i_slope_left),
        .i_slope_right   (i_slope_right),
        .i_edge_low_in   (i_edge_low_in),
        .i_edge_high_in  (i_edge_high_in),
        .i_jump_fraction (r_jump_frac),
        .o_valid         (w_fr_valid),
        .o_flags         (w_fr_flags),
        .o_side          (w_fr_side),
        .o_rem           (w_fr_rem),
        .o_divisor       (w_fr_divisor),
        .o_bits          (w_fr_bits)
    );

    pcs_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (w_fr_valid),
        .i_flags   (w_fr_flags),
        .i_side    (w_fr_side),
        .i_rem     (w_fr_rem),
        .i_divisor (w_fr_divisor),
        .i_bits    (w_fr_bits),
        .o_valid   (w_dv_valid),
        .o_flags   (w_dv_flags),
        .o_side    (w_dv_side),
        .o_quo     (w_dv_quo)
    );

    pcs_eta #(
        .FRAC_BITS (FRAC_BITS)
    ) u_eta (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_en),
        .i_valid      (w_dv_valid),
        .i_flags      (w_dv_flags),
        .i_side       (w_dv_side),
        .i_quo        (w_dv_quo),
        .i_eta_gain   (r_eta_gain),
        .i_eta_offset (r_eta_offset),
        .o_valid      (w_et_valid),
        .o_steep      (w_et_steep),
        .o_eta        (w_et_eta),
        .o_side       (w_et_side)
    );

    pcs_blend #(
        .FRAC_BITS (FRAC_BITS)
    ) u_blend (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (w_et_valid),
        .i_steep   (w_et_steep),
        .i_eta     (w_et_eta),
        .i_side    (w_et_side),
        .o_valid   (o_out_valid),
        .o_steep   (o_steepened),
        .o_edge_lo (o_edge_low_out),
        .o_edge_hi (o_edge_high_out)
    );

endmodule

// File: rtl/core/pcs_front.sv
// pcs_front: first three pipeline stages: magnitudes, jump-threshold
// products, detection compares and divider setup.
// Depends on pcs_pkg.
module pcs_front #(
    parameter int FRAC_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_valid,
    input  logic signed [pcs_pkg::DATA_W-1:0]  i_value_left,
    input  logic signed [pcs_pkg::DATA_W-1:0]  i_value_right,
    input  logic signed [pcs_pkg::DATA_W-1:0]  i_curv_left,
    input  logic signed [pcs_pkg::DATA_W-1:0]  i_curv_right,
    input  logic signed [pcs_pkg::DATA_W-1:0]  i_slope_left,
    input  logic signed [pcs_pkg::DATA_W-1:0]  i_slope_right,
    input  logic signed [pcs_pkg::DATA_W-1:0]  i_edge_low_in,
    input  logic signed [pcs_pkg::DATA_W-1:0]  i_edge_high_in,
    input  logic [pcs_pkg::CFG_W-1:0]          i_jump_fraction,
    output logic                               o_valid,
    output pcs_pkg::t_flags                    o_flags,
    output pcs_pkg::t_side                     o_side,
    output logic [pcs_pkg::MAG_W-1:0]          o_rem,
    output logic [pcs_pkg::MAG_W-1:0]          o_divisor,
    output logic [2*FRAC_BITS+1:0]             o_bits
);
    import pcs_pkg::*;

    localparam int QUO_W = 2*FRAC_BITS + 2;
    localparam int PRD_W = CFG_W + MAG_W;
    localparam int DM_W  = MAG_W + FRAC_BITS;
    localparam int CMP_W = (DM_W > PRD_W) ? DM_W : PRD_W;
    localparam int OVF_W = MAG_W + FRAC_BITS + 2;

    // Stage 1 combinational
    logic signed [DATA_W:0] n_d;
    logic signed [DATA_W:0] n_num;
    logic [DATA_W:0]        n_d_neg;
    logic [DATA_W:0]        n_num_neg;
    logic [DATA_W:0]        n_vl_neg;
    logic [DATA_W:0]        n_vr_neg;
    logic [MAG_W-1:0]       n_mag_d;
    logic [MAG_W-1:0]       n_mag_num;
    logic [MAG_W-1:0]       n_mag_vl;
    logic [MAG_W-1:0]       n_mag_vr;
    logic                   n_opp;
    t_side                  n_side;

    // Stage registers
    logic                   r1_valid;
    logic [MAG_W-1:0]       r1_mag_d;
    logic [MAG_W-1:0]       r1_mag_num;
    logic [MAG_W-1:0]       r1_mag_vl;
    logic [MAG_W-1:0]       r1_mag_vr;
    logic                   r1_opp;
    logic                   r1_neg;
    t_side                  r1_side;

    logic                   r2_valid;
    logic [PRD_W-1:0]       r2_prod_l;
    logic [PRD_W-1:0]       r2_prod_r;
    logic [MAG_W-1:0]       r2_mag_d;
    logic [MAG_W-1:0]       r2_mag_num;
    logic                   r2_opp;
    logic                   r2_neg;
    t_side                  r2_side;

    logic                   r3_valid;
    t_flags                 r3_flags;
    t_side                  r3_side;
    logic [MAG_W-1:0]       r3_rem;
    logic [MAG_W-1:0]       r3_divisor;
    logic [QUO_W-1:0]       r3_bits;

    // Stage 3 combinational
    logic [DM_W-1:0]        n_dm;
    logic                   n_jump;
    logic                   n_ovf;
    logic [DM_W-1:0]        n_num_sh;

    // Differences, magnitudes, curvature signs, blend targets
    always_comb begin
        n_d   = {i_value_right[DATA_W-1], i_value_right}
              - {i_value_left[DATA_W-1], i_value_left};
        n_num = {i_curv_left[DATA_W-1], i_curv_left}
              - {i_curv_right[DATA_W-1], i_curv_right};
        n_d_neg   = -n_d;
        n_num_neg = -n_num;
        n_vl_neg  = -{i_value_left[DATA_W-1], i_value_left};
        n_vr_neg  = -{i_value_right[DATA_W-1], i_value_right};
        n_mag_d   = n_d[DATA_W] ? n_d_neg[MAG_W-1:0] : n_d[MAG_W-1:0];
        n_mag_num = n_num[DATA_W] ? n_num_neg[MAG_W-1:0] : n_num[MAG_W-1:0];
        n_mag_vl  = i_value_left[DATA_W-1] ? n_vl_neg[MAG_W-1:0] : i_value_left;
        n_mag_vr  = i_value_right[DATA_W-1] ? n_vr_neg[MAG_W-1:0] : i_value_right;
        n_opp = (i_curv_left[DATA_W-1] && !i_curv_right[DATA_W-1]
                    && (i_curv_right != '0))
             || (i_curv_right[DATA_W-1] && !i_curv_left[DATA_W-1]
                    && (i_curv_left != '0));
        n_side.edge_lo = i_edge_low_in;
        n_side.edge_hi = i_edge_high_in;
        n_side.tgt_lo  = {i_value_left[DATA_W-1], i_value_left, 1'b0}
                       + {{2{i_slope_left[DATA_W-1]}}, i_slope_left};
        n_side.tgt_hi  = {i_value_right[DATA_W-1], i_value_right, 1'b0}
                       - {{2{i_slope_right[DATA_W-1]}}, i_slope_right};
    end

    // Jump test, quotient range check, divider start values
    always_comb begin
        n_dm     = {r2_mag_d, {FRAC_BITS{1'b0}}};
        n_jump   = (CMP_W'(n_dm) > CMP_W'(r2_prod_l))
                && (CMP_W'(n_dm) > CMP_W'(r2_prod_r));
        n_ovf    = OVF_W'(r2_mag_num) >= (OVF_W'(r2_mag_d) << (FRAC_BITS + 2));
        n_num_sh = {r2_mag_num, {FRAC_BITS{1'b0}}};
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_mag_d   <= n_mag_d;
            r1_mag_num <= n_mag_num;
            r1_mag_vl  <= n_mag_vl;
            r1_mag_vr  <= n_mag_vr;
            r1_opp     <= n_opp;
            r1_neg     <= n_num[DATA_W] ^ n_d[DATA_W];
            r1_side    <= n_side;

            r2_prod_l  <= i_jump_fraction * r1_mag_vl;
            r2_prod_r  <= i_jump_fraction * r1_mag_vr;
            r2_mag_d   <= r1_mag_d;
            r2_mag_num <= r1_mag_num;
            r2_opp     <= r1_opp;
            r2_neg     <= r1_neg;
            r2_side    <= r1_side;

            r3_flags.pass <= r2_opp && n_jump;
            r3_flags.neg  <= r2_neg;
            r3_flags.ovf  <= n_ovf;
            r3_side       <= r2_side;
            r3_rem        <= MAG_W'(n_num_sh[DM_W-1:QUO_W]);
            r3_divisor    <= r2_mag_d;
            r3_bits       <= n_num_sh[QUO_W-1:0];
        end
    end

    assign o_valid   = r3_valid;
    assign o_flags   = r3_flags;
    assign o_side    = r3_side;
    assign o_rem     = r3_rem;
    assign o_divisor = r3_divisor;
    assign o_bits    = r3_bits;

endmodule

// File: rtl/core/pcs_div.sv
// pcs_div: pipelined restoring divider, one quotient bit per stage,
// for the curvature ratio |num|*2^F / |d|.
// Depends on pcs_pkg.
module pcs_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  pcs_pkg::t_flags            i_flags,
    input  pcs_pkg::t_side             i_side,
    input  logic [pcs_pkg::MAG_W-1:0]  i_rem,
    input  logic [pcs_pkg::MAG_W-1:0]  i_divisor,
    input  logic [2*FRAC_BITS+1:0]     i_bits,
    output logic                       o_valid,
    output pcs_pkg::t_flags            o_flags,
    output pcs_pkg::t_side             o_side,
    output logic [2*FRAC_BITS+1:0]     o_quo
);
    import pcs_pkg::*;

    localparam int QUO_W = 2*FRAC_BITS + 2;

    // Stage inputs: entry 0 from the ports, entry k from stage k-1
    logic [MAG_W-1:0] s_rem   [QUO_W];
    logic [MAG_W-1:0] s_div   [QUO_W];
    logic [QUO_W-1:0] s_bits  [QUO_W];
    logic [QUO_W-1:0] s_quo   [QUO_W];
    t_flags           s_flags [QUO_W];
    t_side            s_side  [QUO_W];

    // Per-stage next values
    logic [MAG_W:0]   n_trial [QUO_W];
    logic [MAG_W:0]   n_sub   [QUO_W];
    logic [QUO_W-1:0] n_take;
    logic [MAG_W-1:0] n_rem   [QUO_W];
    logic [QUO_W-1:0] n_quo   [QUO_W];
    logic [QUO_W-1:0] n_bits  [QUO_W];

    // Stage registers
    logic [QUO_W-1:0] r_valid;
    logic [MAG_W-1:0] r_rem   [QUO_W];
    logic [MAG_W-1:0] r_div   [QUO_W];
    logic [QUO_W-1:0] r_bits  [QUO_W];
    logic [QUO_W-1:0] r_quo   [QUO_W];
    t_flags           r_flags [QUO_W];
    t_side            r_side  [QUO_W];

    // Chain stage inputs
    always_comb begin
        s_rem[0]   = i_rem;
        s_div[0]   = i_divisor;
        s_bits[0]  = i_bits;
        s_quo[0]   = '0;
        s_flags[0] = i_flags;
        s_side[0]  = i_side;
        for (int k = 1; k < QUO_W; k++) begin
            s_rem[k]   = r_rem[k-1];
            s_div[k]   = r_div[k-1];
            s_bits[k]  = r_bits[k-1];
            s_quo[k]   = r_quo[k-1];
            s_flags[k] = r_flags[k-1];
            s_side[k]  = r_side[k-1];
        end
    end

    // One trial subtract per stage
    always_comb begin
        for (int k = 0; k < QUO_W; k++) begin
            n_trial[k] = {s_rem[k], s_bits[k][QUO_W-1]};
            n_sub[k]   = n_trial[k] - {1'b0, s_div[k]};
            n_take[k]  = n_trial[k] >= {1'b0, s_div[k]};
            n_rem[k]   = n_take[k] ? n_sub[k][MAG_W-1:0] : n_trial[k][MAG_W-1:0];
            n_quo[k]   = {s_quo[k][QUO_W-2:0], n_take[k]};
            n_bits[k]  = {s_bits[k][QUO_W-2:0], 1'b0};
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[QUO_W-2:0], i_valid};
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < QUO_W; k++) begin
                r_rem[k]   <= n_rem[k];
                r_div[k]   <= s_div[k];
                r_bits[k]  <= n_bits[k];
                r_quo[k]   <= n_quo[k];
                r_flags[k] <= s_flags[k];
                r_side[k]  <= s_side[k];
            end
        end
    end

    assign o_valid = r_valid[QUO_W-1];
    assign o_flags = r_flags[QUO_W-1];
    assign o_side  = r_side[QUO_W-1];
    assign o_quo   = r_quo[QUO_W-1];

endmodule

// File: rtl/core/pcs_eta.sv
// pcs_eta: four stages that turn the curvature ratio into the blend
// weight eta = min(1, gain*(ratio-offset)), with the product split in two.
// Depends on pcs_pkg.
module pcs_eta #(
    parameter int FRAC_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  pcs_pkg::t_flags            i_flags,
    input  pcs_pkg::t_side             i_side,
    input  logic [2*FRAC_BITS+1:0]     i_quo,
    input  logic [pcs_pkg::CFG_W-1:0]  i_eta_gain,
    input  logic [pcs_pkg::CFG_W-1:0]  i_eta_offset,
    output logic                       o_valid,
    output logic                       o_steep,
    output logic [FRAC_BITS:0]         o_eta,
    output pcs_pkg::t_side             o_side
);
    import pcs_pkg::*;

    localparam int QUO_W = 2*FRAC_BITS + 2;
    localparam int DIF_W = (QUO_W > CFG_W) ? QUO_W : CFG_W;
    localparam int LO_W  = CFG_W + FRAC_BITS;
    localparam int HI_W  = CFG_W + FRAC_BITS + 1;
    localparam int SUM_W = HI_W + 1;
    localparam logic [DIF_W-1:0] DIFF_LIM = DIF_W'(1) << (2*FRAC_BITS);
    localparam logic [FRAC_BITS:0] ETA_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    typedef enum logic [1:0] {
        ETA_ZERO,
        ETA_FULL,
        ETA_CALC
    } t_eta_mode;

    // Stage 1 and stage 4 combinational
    logic [DIF_W-1:0]   n1_quo;
    logic [DIF_W-1:0]   n1_off;
    logic [DIF_W-1:0]   n1_diff;
    t_eta_mode          n1_mode;
    logic [SUM_W-1:0]   n4_sum;
    logic [FRAC_BITS:0] n4_eta;

    // Stage registers
    logic               r1_valid;
    t_eta_mode          r1_mode;
    logic [FRAC_BITS:0] r1_dh;
    logic [FRAC_BITS-1:0] r1_dl;
    logic               r1_steep;
    t_side              r1_side;

    logic               r2_valid;
    t_eta_mode          r2_mode;
    logic [FRAC_BITS:0] r2_dh;
    logic [LO_W-1:0]    r2_plo;
    logic               r2_steep;
    t_side              r2_side;

    logic               r3_valid;
    t_eta_mode          r3_mode;
    logic [HI_W-1:0]    r3_phi;
    logic [CFG_W-1:0]   r3_plo_hi;
    logic               r3_steep;
    t_side              r3_side;

    logic               r4_valid;
    logic [FRAC_BITS:0] r4_eta;
    logic               r4_steep;
    t_side              r4_side;

    // Classify: weight zero, weight one, or needs the product
    always_comb begin
        n1_quo  = DIF_W'(i_quo);
        n1_off  = DIF_W'(i_eta_offset);
        n1_diff = n1_quo - n1_off;
        if (!i_flags.pass || i_flags.neg || (i_eta_gain == '0)) begin
            n1_mode = ETA_ZERO;
        end else if (i_flags.ovf) begin
            n1_mode = ETA_FULL;
        end else if (n1_quo <= n1_off) begin
            n1_mode = ETA_ZERO;
        end else if (n1_diff > DIFF_LIM) begin
            n1_mode = ETA_FULL;
        end else begin
            n1_mode = ETA_CALC;
        end
    end

    // Combine partial products and clamp
    always_comb begin
        n4_sum = SUM_W'(r3_phi) + SUM_W'(r3_plo_hi);
        case (r3_mode)
            ETA_FULL: n4_eta = ETA_ONE;
            ETA_CALC: n4_eta = (n4_sum > SUM_W'(ETA_ONE)) ? ETA_ONE : n4_sum[FRAC_BITS:0];
            default:  n4_eta = '0;
        endcase
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_mode   <= n1_mode;
            r1_dh     <= n1_diff[2*FRAC_BITS:FRAC_BITS];
            r1_dl     <= n1_diff[FRAC_BITS-1:0];
            r1_steep  <= i_flags.pass;
            r1_side   <= i_side;

            r2_mode   <= r1_mode;
            r2_dh     <= r1_dh;
            r2_plo    <= i_eta_gain * r1_dl;
            r2_steep  <= r1_steep;
            r2_side   <= r1_side;

            r3_mode   <= r2_mode;
            r3_phi    <= i_eta_gain * r2_dh;
            r3_plo_hi <= r2_plo[LO_W-1:FRAC_BITS];
            r3_steep  <= r2_steep;
            r3_side   <= r2_side;

            r4_eta    <= n4_eta;
            r4_steep  <= r3_steep;
            r4_side   <= r3_side;
        end
    end

    assign o_valid = r4_valid;
    assign o_steep = r4_steep;
    assign o_eta   = r4_eta;
    assign o_side  = r4_side;

endmodule

// File: rtl/core/pcs_blend.sv
// pcs_blend: blends both interface values toward their steepened targets,
// rounds, saturates; the last stage is the output register.
// Depends on pcs_pkg.
module pcs_blend #(
    parameter int FRAC_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_valid,
    input  logic                               i_steep,
    input  logic [FRAC_BITS:0]                 i_eta,
    input  pcs_pkg::t_side                     i_side,
    output logic                               o_valid,
    output logic                               o_steep,
    output logic signed [pcs_pkg::DATA_W-1:0]  o_edge_lo,
    output logic signed [pcs_pkg::DATA_W-1:0]  o_edge_hi
);
    import pcs_pkg::*;

    localparam int W_W   = FRAC_BITS + 1;
    localparam int M1_W  = DATA_W + W_W + 1;
    localparam int M2_W  = TGT_W + W_W + 1;
    localparam int ACC_W = M2_W + 2;
    localparam int UP_W  = ACC_W - DATA_W + 1;
    localparam logic [W_W-1:0] ETA_ONE = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << FRAC_BITS;

    // Round-shifted accumulator to 32 bits with saturation
    function automatic logic [DATA_W-1:0] sat_word(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] sh;
        logic [UP_W-1:0]         upper;
        sh    = v >>> (FRAC_BITS + 1);
        upper = sh[ACC_W-1:DATA_W-1];
        if ((upper == '0) || (upper == '1)) begin
            return sh[DATA_W-1:0];
        end else if (sh[ACC_W-1]) begin
            return {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            return {1'b0, {(DATA_W-1){1'b1}}};
        end
    endfunction

    logic [W_W-1:0]           n_w;
    logic signed [ACC_W-1:0]  n_acc_lo;
    logic signed [ACC_W-1:0]  n_acc_hi;

    logic                     r1_valid;
    logic signed [M1_W-1:0]   r1_m1_lo;
    logic signed [M1_W-1:0]   r1_m1_hi;
    logic signed [TGT_W-1:0]  r1_tgt_lo;
    logic signed [TGT_W-1:0]  r1_tgt_hi;
    logic [W_W-1:0]           r1_eta;
    logic                     r1_steep;

    logic                     r2_valid;
    logic signed [M1_W-1:0]   r2_m1_lo;
    logic signed [M1_W-1:0]   r2_m1_hi;
    logic signed [M2_W-1:0]   r2_m2_lo;
    logic signed [M2_W-1:0]   r2_m2_hi;
    logic                     r2_steep;

    logic                     r3_valid;
    logic signed [ACC_W-1:0]  r3_acc_lo;
    logic signed [ACC_W-1:0]  r3_acc_hi;
    logic                     r3_steep;

    logic                     r4_valid;
    logic signed [DATA_W-1:0] r4_edge_lo;
    logic signed [DATA_W-1:0] r4_edge_hi;
    logic                     r4_steep;

    // Weight of the old interface value
    assign n_w = ETA_ONE - i_eta;

    // edge*(1-eta)*2 + target*eta + half
    always_comb begin
        n_acc_lo = (ACC_W'(r2_m1_lo) <<< 1) + ACC_W'(r2_m2_lo) + HALF;
        n_acc_hi = (ACC_W'(r2_m1_hi) <<< 1) + ACC_W'(r2_m2_hi) + HALF;
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_m1_lo   <= $signed(i_side.edge_lo) * $signed({1'b0, n_w});
            r1_m1_hi   <= $signed(i_side.edge_hi) * $signed({1'b0, n_w});
            r1_tgt_lo  <= i_side.tgt_lo;
            r1_tgt_hi  <= i_side.tgt_hi;
            r1_eta     <= i_eta;
            r1_steep   <= i_steep;

            r2_m1_lo   <= r1_m1_lo;
            r2_m1_hi   <= r1_m1_hi;
            r2_m2_lo   <= r1_tgt_lo * $signed({1'b0, r1_eta});
            r2_m2_hi   <= r1_tgt_hi * $signed({1'b0, r1_eta});
            r2_steep   <= r1_steep;

            r3_acc_lo  <= n_acc_lo;
            r3_acc_hi  <= n_acc_hi;
            r3_steep   <= r2_steep;

            r4_edge_lo <= sat_word(r3_acc_lo);
            r4_edge_hi <= sat_word(r3_acc_hi);
            r4_steep   <= r3_steep;
        end
    end

    assign o_valid   = r4_valid;
    assign o_steep   = r4_steep;
    assign o_edge_lo = r4_edge_lo;
    assign o_edge_hi = r4_edge_hi;

endmodule

// File: tb/ppa_contact_steepener_unit_tb.sv
// Self-checking testbench for ppa_contact_steepener_unit: directed and random interface
// items under several register settings, with a bit-exact predictor of the steepening math.
// Depends on pcs_pkg and the ppa_contact_steepener_unit RTL.
`timescale 1ns / 1ps

module ppa_contact_steepener_unit_tb;
    import pcs_pkg::*;

    localparam int FRAC_BITS = 16;
    localparam longint ONE_Q = 64'sd1 << FRAC_BITS;
    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;
    // index with no register behind it, the block must ignore writes to it
    localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic signed [DATA_W-1:0] value_left;
        logic signed [DATA_W-1:0] value_right;
        logic signed [DATA_W-1:0] curv_left;
        logic signed [DATA_W-1:0] curv_right;
        logic signed [DATA_W-1:0] slope_left;
        logic signed [DATA_W-1:0] slope_right;
        logic signed [DATA_W-1:0] edge_low_in;
        logic signed [DATA_W-1:0] edge_high_in;
    } t_iface_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] edge_low;
        logic signed [DATA_W-1:0] edge_high;
        logic                     steep;
    } t_iface_result;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_we = 1'b0;
    logic [IDX_W-1:0]         i_cfg_index = '0;
    logic [CFG_W-1:0]         i_cfg_data = '0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_ready;
    logic signed [DATA_W-1:0] i_value_left = '0;
    logic signed [DATA_W-1:0] i_value_right = '0;
    logic signed [DATA_W-1:0] i_curv_left = '0;
    logic signed [DATA_W-1:0] i_curv_right = '0;
    logic signed [DATA_W-1:0] i_slope_left = '0;
    logic signed [DATA_W-1:0] i_slope_right = '0;
    logic signed [DATA_W-1:0] i_edge_low_in = '0;
    logic signed [DATA_W-1:0] i_edge_high_in = '0;
    logic                     o_out_valid;
    logic                     i_out_ready = 1'b0;
    logic signed [DATA_W-1:0] o_edge_low_out;
    logic signed [DATA_W-1:0] o_edge_high_out;
    logic                     o_steepened;

    // Register copies used by the predictor
    longint unsigned gain_q   = ETA_GAIN_RST;
    longint unsigned offset_q = ETA_OFFSET_RST;
    longint unsigned jump_q   = JUMP_FRAC_RST;

    t_iface_item   pending_items[$];
    t_iface_result expected_edges[$];
    t_iface_item   in_cur;
    int in_gap = 0;
    int out_gap = 0;
    int in_gap_pct = 0;
    int out_gap_pct = 0;
    int n_errors = 0;
    int n_results = 0;
    int n_steep = 0;
    int n_sat = 0;
    int n_settings = 1;

    ppa_contact_steepener_unit #(
        .FRAC_BITS(FRAC_BITS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_value_left   (i_value_left),
        .i_value_right  (i_value_right),
        .i_curv_left    (i_curv_left),
        .i_curv_right   (i_curv_right),
        .i_slope_left   (i_slope_left),
        .i_slope_right  (i_slope_right),
        .i_edge_low_in  (i_edge_low_in),
        .i_edge_high_in (i_edge_high_in),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_edge_low_out (o_edge_low_out),
        .o_edge_high_out(o_edge_high_out),
        .o_steepened    (o_steepened)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic longint unsigned mag64(longint x);
        return (x < 0) ? -x : x;
    endfunction

    // Blend one edge toward its linear target; exact sum, round half up, saturate
    function automatic logic signed [DATA_W-1:0] blend_edge(longint edge_v, longint tgt2,
                                                            longint eta);
        longint acc;
        longint q;
        acc = edge_v * (ONE_Q - eta) * 2 + tgt2 * eta;
        q = (acc + ONE_Q) >>> (FRAC_BITS + 1);   // ONE_Q is half an LSB of the result
        if (q > S32_MAX) q = S32_MAX;
        else if (q < S32_MIN) q = S32_MIN;
        return q[DATA_W-1:0];
    endfunction

    // Expected result of one interface item under the current register values
    function automatic t_iface_result steepen_predict(t_iface_item it);
        longint vl, vr, cl, cr, d, num, ratio, eta;
        longint unsigned dm, qm, diff, prod;
        logic opposite, jump;
        t_iface_result r;
        vl = $signed(it.value_left);
        vr = $signed(it.value_right);
        cl = $signed(it.curv_left);
        cr = $signed(it.curv_right);
        opposite = (cl < 0 && cr > 0) || (cl > 0 && cr < 0);
        d = vr - vl;
        dm = mag64(d) << FRAC_BITS;
        jump = (dm > jump_q * mag64(vl)) && (dm > jump_q * mag64(vr));
        if (!(opposite && jump)) begin
            r.edge_low = it.edge_low_in;
            r.edge_high = it.edge_high_in;
            r.steep = 1'b0;
            return r;
        end
        // curvature jump over value jump, truncated toward zero
        num = cl - cr;
        qm = (mag64(num) << FRAC_BITS) / mag64(d);
        ratio = ((num < 0) != (d < 0)) ? -longint'(qm) : longint'(qm);
        eta = 0;
        if (ratio > longint'(offset_q) && gain_q != 0) begin
            diff = ratio - longint'(offset_q);
            if (diff > (64'd1 << (2 * FRAC_BITS)) / gain_q) begin
                eta = ONE_Q;
            end else begin
                prod = (gain_q * diff) >> FRAC_BITS;
                eta = (prod > ONE_Q) ? ONE_Q : longint'(prod);
            end
        end
        r.edge_low = blend_edge($signed(it.edge_low_in), 2 * vl + $signed(it.slope_left), eta);
        r.edge_high = blend_edge($signed(it.edge_high_in), 2 * vr - $signed(it.slope_right),
                                 eta);
        r.steep = 1'b1;
        return r;
    endfunction

    function automatic t_iface_item mk(longint vl, longint vr, longint cl, longint cr,
                                       longint sl, longint sr, longint el, longint eh);
        t_iface_item it;
        it.value_left = vl[31:0];
        it.value_right = vr[31:0];
        it.curv_left = cl[31:0];
        it.curv_right = cr[31:0];
        it.slope_left = sl[31:0];
        it.slope_right = sr[31:0];
        it.edge_low_in = el[31:0];
        it.edge_high_in = eh[31:0];
        return it;
    endfunction

    // uniform in [-m, m], m capped at 2^30
    function automatic longint srand(longint m);
        longint lim;
        lim = (m > 64'sd1073741824) ? 64'sd1073741824 : m;
        return longint'($urandom_range(0, 32'(2 * lim))) - lim;
    endfunction

    function automatic longint rand_word();
        return longint'($signed($urandom()));
    endfunction

    function automatic longint corner_word();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return S32_MAX;
            2: return S32_MIN;
            3: return 1;
            4: return -1;
            default: return rand_word();
        endcase
    endfunction

    // Item built around a target curvature ratio near the partial-blend window
    function automatic t_iface_item shaped_item();
        longint vl, vr, d, dmag, span, ratio, num, cl, cr, sl, sr, el, eh;
        int k;
        k = $urandom_range(0, 20);
        dmag = 1 + longint'($urandom_range(0, (1 << k) - 1));
        d = $urandom_range(0, 1) ? dmag : -dmag;
        if ($urandom_range(0, 19) == 0) d = 0;
        if ($urandom_range(0, 9) == 0) vl = srand(64'sd1 << 30);
        else vl = srand(dmag * $urandom_range(1, 150));
        vr = vl + d;
        span = (gain_q == 0) ? (64'sd1 << 20) : longint'((64'd1 << 32) / gain_q) + 1;
        if (span > (64'sd1 << 33)) span = 64'sd1 << 33;
        if ($urandom_range(0, 9) == 0)
            ratio = -longint'($urandom_range(0, 1 << 20));
        else
            ratio = longint'(offset_q) + span * (longint'($urandom_range(0, 1000)) - 100) / 800;
        num = ratio * d / ONE_Q;
        if (num > 64'sd2147483645) num = 64'sd2147483645;
        if (num < -64'sd2147483645) num = -64'sd2147483645;
        // split the curvature jump into two values of opposite sign
        if (num >= 2) begin
            cl = 1 + longint'($urandom_range(0, 32'(num - 2)));
        end else if (num <= -2) begin
            cl = -1 - longint'($urandom_range(0, 32'(-num - 2)));
        end else begin
            cl = num;
        end
        cr = cl - num;
        if ($urandom_range(0, 9) == 0) cr = -cr;   // same-sign curvature, must pass through
        sl = ($urandom_range(0, 4) == 0) ? rand_word() : srand(dmag * 4);
        sr = ($urandom_range(0, 4) == 0) ? rand_word() : srand(dmag * 4);
        el = ($urandom_range(0, 4) == 0) ? rand_word() : vl + srand(dmag);
        eh = ($urandom_range(0, 4) == 0) ? rand_word() : vr + srand(dmag);
        return mk(vl, vr, cl, cr, sl, sr, el, eh);
    endfunction

    task automatic add_random(int count);
        int pick;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                pending_items.push_back(shaped_item());
            else if (pick < 85)
                pending_items.push_back(mk(rand_word(), rand_word(), rand_word(), rand_word(),
                                           rand_word(), rand_word(), rand_word(), rand_word()));
            else
                pending_items.push_back(mk(corner_word(), corner_word(), corner_word(),
                                           corner_word(), corner_word(), corner_word(),
                                           corner_word(), corner_word()));
        end
    endtask

    // Block until every queued item has been accepted and answered
    task automatic wait_drain();
        while (pending_items.size() != 0 || i_in_valid || expected_edges.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_ETA_GAIN:   gain_q = longint'(val);
            REG_ETA_OFFSET: offset_q = longint'(val);
            REG_JUMP_FRAC:  jump_q = longint'(val);
            default: ;
        endcase
    endtask

    task automatic apply_config(logic [CFG_W-1:0] gain, logic [CFG_W-1:0] offset,
                                logic [CFG_W-1:0] jump);
        write_reg(REG_ETA_GAIN, gain);
        write_reg(REG_ETA_OFFSET, offset);
        write_reg(REG_JUMP_FRAC, jump);
        n_settings++;
    endtask

    // Input side: acceptance, prediction and the next item
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready)
                expected_edges.push_back(steepen_predict(in_cur));
            if (!i_in_valid || o_in_ready) begin
                if (in_gap > 0) begin
                    in_gap--;
                    i_in_valid <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    in_cur = pending_items.pop_front();
                    i_value_left <= in_cur.value_left;
                    i_value_right <= in_cur.value_right;
                    i_curv_left <= in_cur.curv_left;
                    i_curv_right <= in_cur.curv_right;
                    i_slope_left <= in_cur.slope_left;
                    i_slope_right <= in_cur.slope_right;
                    i_edge_low_in <= in_cur.edge_low_in;
                    i_edge_high_in <= in_cur.edge_high_in;
                    i_in_valid <= 1'b1;
                    if ($urandom_range(0, 99) < in_gap_pct)
                        in_gap = $urandom_range(1, 14);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Output side: random stalls and comparison against the oldest prediction
    always @(posedge i_clk) begin : result_side
        t_iface_result want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_edges.size() == 0) begin
                    $display("%0t ns: result with no item outstanding", $time);
                    n_errors++;
                end else begin
                    want = expected_edges.pop_front();
                    n_results++;
                    if (want.steep) n_steep++;
                    if (want.edge_low == S32_MAX || want.edge_low == S32_MIN) n_sat++;
                    if (want.edge_high == S32_MAX || want.edge_high == S32_MIN) n_sat++;
                    if (o_edge_low_out !== want.edge_low) begin
                        $display("%0t ns: edge_low_out expected %0d got %0d",
                                 $time, want.edge_low, o_edge_low_out);
                        n_errors++;
                    end
                    if (o_edge_high_out !== want.edge_high) begin
                        $display("%0t ns: edge_high_out expected %0d got %0d",
                                 $time, want.edge_high, o_edge_high_out);
                        n_errors++;
                    end
                    if (o_steepened !== want.steep) begin
                        $display("%0t ns: steepened expected %0b got %0b",
                                 $time, want.steep, o_steepened);
                        n_errors++;
                    end
                end
            end
            if (out_gap > 0) begin
                out_gap--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                if ($urandom_range(0, 99) < out_gap_pct)
                    out_gap = $urandom_range(1, 14);
            end
        end
    end

    // Stimulus sequence
    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset values, directed corners first
        in_gap_pct = 12;
        out_gap_pct = 12;
        pending_items.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(mk(S32_MAX, S32_MAX, S32_MAX, S32_MAX,
                                   S32_MAX, S32_MAX, S32_MAX, S32_MAX));
        pending_items.push_back(mk(S32_MIN, S32_MIN, S32_MIN, S32_MIN,
                                   S32_MIN, S32_MIN, S32_MIN, S32_MIN));
        // full blend, partial blend near one half, ratio right at the offset
        pending_items.push_back(mk(0, 65536, 65536, -65536, 32768, -32768, 1000, 70000));
        pending_items.push_back(mk(0, 65536, 2458, -2457, 6553, 13107, 1, -1));
        pending_items.push_back(mk(0, 65536, 2459, -2457, 1, -1, 3, -3));
        pending_items.push_back(mk(0, 65536, 1639, -1638, 6553, 13107, 12345, 54321));
        // negative ratio: flagged with no blending
        pending_items.push_back(mk(0, 65536, -65536, 65536, 100, 200, 300, 400));
        // same-sign and zero curvature, zero jump
        pending_items.push_back(mk(0, 65536, 65536, 65536, 100, 200, 300, 400));
        pending_items.push_back(mk(0, 65536, 0, -65536, 100, 200, 300, 400));
        pending_items.push_back(mk(1000, 1000, 65536, -65536, 5, 6, 7, 8));
        // jump exactly at the threshold, then one step past it
        pending_items.push_back(mk(65536, 64881, 65536, -65536, 0, 0, 65536, 64881));
        pending_items.push_back(mk(65536, 64880, -65536, 65536, 0, 0, 65536, 64880));
        // saturation toward both rails
        pending_items.push_back(mk(64'sd1 << 30, S32_MAX, S32_MAX, S32_MIN,
                                   S32_MAX, S32_MIN, 0, 0));
        pending_items.push_back(mk(S32_MIN, -(64'sd1 << 30), S32_MAX, S32_MIN,
                                   S32_MIN, S32_MAX, 0, 0));
        // widest value jumps in both directions
        pending_items.push_back(mk(S32_MIN, S32_MAX, S32_MAX, S32_MIN,
                                   12345, -12345, S32_MIN, S32_MAX));
        pending_items.push_back(mk(S32_MAX, S32_MIN, S32_MIN, S32_MAX,
                                   -1, 1, S32_MAX, S32_MIN));
        // smallest opposite curvatures and unit jumps
        pending_items.push_back(mk(0, 1, 1, -1, 3, 5, 7, 9));
        pending_items.push_back(mk(0, -1, -1, 1, -3, -5, -7, -9));
        pending_items.push_back(mk(5, 7, 65536, 65535, S32_MIN, S32_MAX, S32_MIN, S32_MAX));
        add_random(300);
        wait_drain();

        // Extremes: largest gain, no offset, no jump threshold
        apply_config(31'h7FFF_FFFF, 31'd0, 31'd0);
        in_gap_pct = 8;
        out_gap_pct = 30;
        add_random(250);
        wait_drain();

        // Zero gain with largest offset and threshold, then a tiny gain
        apply_config(31'd0, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
        in_gap_pct = 30;
        out_gap_pct = 5;
        add_random(100);
        wait_drain();
        apply_config(31'd1, 31'd0, 31'd1);
        add_random(100);
        wait_drain();

        // Random register values across scales
        for (int p = 0; p < 3; p++) begin
            apply_config(CFG_W'($urandom() >> $urandom_range(1, 31)),
                         CFG_W'($urandom() >> $urandom_range(12, 31)),
                         CFG_W'($urandom() >> $urandom_range(9, 31)));
            in_gap_pct = $urandom_range(0, 30);
            out_gap_pct = $urandom_range(0, 30);
            add_random(100);
            wait_drain();
        end

        // Unmapped index must not disturb anything; back to defaults, no idling
        write_reg(REG_SPARE, CFG_W'($urandom()));
        apply_config(ETA_GAIN_RST, ETA_OFFSET_RST, JUMP_FRAC_RST);
        in_gap_pct = 0;
        out_gap_pct = 0;
        add_random(380);
        wait_drain();
        repeat (60) @(posedge i_clk);

        $display("Checked %0d results (%0d steepened, %0d saturated edges) over %0d settings",
                 n_results, n_steep, n_sat, n_settings);
        if (n_errors == 0)
            $display("ppa_contact_steepener_unit verification clean");
        else
            $display("ppa_contact_steepener_unit verification failed");
        $finish;
    end

    // Watchdog
    initial begin
        #4_000_000;
        $display("Timeout with %0d results outstanding", expected_edges.size());
        $display("ppa_contact_steepener_unit verification failed");
        $finish;
    end

endmodule
